[hw/rtl/mct_pkg.sv]
package mct_pkg;

  // Field widths
  localparam int unsigned PRICE_W         = 32;
  localparam int unsigned EXTRA_FRAC_BITS = 8;
  localparam int unsigned AVG_W           = PRICE_W + EXTRA_FRAC_BITS;  // price EMAs, Q16.24
  localparam int unsigned MACD_W          = AVG_W + 1;                  // macd and signal
  localparam int unsigned NUM_W           = MACD_W + 2;                 // 2 * (target - avg)
  localparam int unsigned LIMIT_W         = 16;
  localparam int unsigned POS_W           = LIMIT_W + 1;
  localparam int unsigned CASH_W          = 63;
  localparam int unsigned PROD_W          = PRICE_W + 1 + POS_W;
  localparam int unsigned DEN_W           = 5;
  localparam int unsigned STEP_W          = 4;

  // EMA denominators (alpha = 2 / D)
  localparam logic [DEN_W-1:0] SLOW_DEN   = DEN_W'(27);
  localparam logic [DEN_W-1:0] FAST_DEN   = DEN_W'(13);
  localparam logic [DEN_W-1:0] SIGNAL_DEN = DEN_W'(10);

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_BUY  = 2'd1,
    DIR_SELL = 2'd2
  } order_dir_e;

  // Micro-operations of the datapath
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_LATCH,
    UOP_INIT,
    UOP_DIV_SLOW,
    UOP_WB_SLOW,
    UOP_DIV_FAST,
    UOP_WB_FAST,
    UOP_MACD,
    UOP_DIV_SIG,
    UOP_WB_SIG,
    UOP_TRADE,
    UOP_MUL,
    UOP_SETTLE
  } uop_e;

  // Conditions that hold the sequencer on its current step
  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_DIV,
    HOLD_OUT
  } hold_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_NOT_FIRST
  } jump_e;

  typedef struct packed {
    uop_e              uop;
    hold_e             hold;
    jump_e             jump;
    logic [STEP_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [NUM_W-1:0] quot;
  } div_rsp_t;

  // Program addresses
  localparam logic [STEP_W-1:0] STEP_IDLE     = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_INIT     = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_DIV_SLOW = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_WB_SLOW  = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_DIV_FAST = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_WB_FAST  = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_MACD     = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_DIV_SIG  = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_WB_SIG   = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_TRADE    = STEP_W'(9);
  localparam logic [STEP_W-1:0] STEP_MUL      = STEP_W'(10);
  localparam logic [STEP_W-1:0] STEP_SETTLE   = STEP_W'(11);

  // Control store: one word per step
  function automatic ctl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctl_word_t w;
    w = '{uop: UOP_NOP, hold: HOLD_NONE, jump: JMP_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE:     w = '{UOP_LATCH,    HOLD_IN,   JMP_NOT_FIRST, STEP_DIV_SLOW};
      STEP_INIT:     w = '{UOP_INIT,     HOLD_NONE, JMP_NEXT,      STEP_IDLE};
      STEP_DIV_SLOW: w = '{UOP_DIV_SLOW, HOLD_NONE, JMP_NEXT,      STEP_IDLE};
      STEP_WB_SLOW:  w = '{UOP_WB_SLOW,  HOLD_DIV,  JMP_NEXT,      STEP_IDLE};
      STEP_DIV_FAST: w = '{UOP_DIV_FAST, HOLD_NONE, JMP_NEXT,      STEP_IDLE};
      STEP_WB_FAST:  w = '{UOP_WB_FAST,  HOLD_DIV,  JMP_NEXT,      STEP_IDLE};
      STEP_MACD:     w = '{UOP_MACD,     HOLD_NONE, JMP_NEXT,      STEP_IDLE};
      STEP_DIV_SIG:  w = '{UOP_DIV_SIG,  HOLD_NONE, JMP_NEXT,      STEP_IDLE};
      STEP_WB_SIG:   w = '{UOP_WB_SIG,   HOLD_DIV,  JMP_NEXT,      STEP_IDLE};
      STEP_TRADE:    w = '{UOP_TRADE,    HOLD_NONE, JMP_NEXT,      STEP_IDLE};
      STEP_MUL:      w = '{UOP_MUL,      HOLD_NONE, JMP_NEXT,      STEP_IDLE};
      STEP_SETTLE:   w = '{UOP_SETTLE,   HOLD_OUT,  JMP_ALWAYS,    STEP_IDLE};
      default:       w = '{UOP_NOP,      HOLD_NONE, JMP_ALWAYS,    STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/macd_crossover_trader.sv]
// Channel   Handshake                 Beat contents
// in        in_valid_i / in_ready_o   close_price_i, first_sample_i
// out       out_valid_o / out_ready_i order_dir_o, held_units_o, cash_balance_o,
//                                     settled_value_o, macd_value_o, signal_value_o
// cfg       cfg_valid_i / cfg_ready_o position_limit_i
//
// Each item is stepped by the microcode sequencer through three runs of the
// shared constant divider (four quotient bits per cycle), with an extra init
// step when first_sample_i is set. A new input beat is taken only once the
// previous item has left the sequencer's last step.
// Reset clears all averages, position, cash and the limit; nothing to sweep.
// A stalled result is held in the output register while the next input
// beat is taken; the sequencer waits at its last step until the slot frees.
module macd_crossover_trader (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [mct_pkg::PRICE_W-1:0]          close_price_i,
  input  logic                                 first_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           order_dir_o,
  output logic signed [mct_pkg::POS_W-1:0]     held_units_o,
  output logic signed [mct_pkg::CASH_W-1:0]    cash_balance_o,
  output logic signed [mct_pkg::CASH_W-1:0]    settled_value_o,
  output logic signed [mct_pkg::MACD_W-1:0]    macd_value_o,
  output logic signed [mct_pkg::MACD_W-1:0]    signal_value_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mct_pkg::LIMIT_W-1:0]          position_limit_i
);
  import mct_pkg::*;

  // Sequencer
  logic [STEP_W-1:0] step_q, step_d;
  ctl_word_t         ctl;
  logic              stall;
  logic              exec;
  logic              jump_taken;

  // Architectural state
  logic [AVG_W-1:0]          slow_q;
  logic [AVG_W-1:0]          fast_q;
  logic signed [MACD_W-1:0]  sig_q;
  logic signed [POS_W-1:0]   pos_q;
  logic signed [CASH_W-1:0]  cash_q;
  logic [LIMIT_W-1:0]        limit_q;

  // Working registers
  logic [PRICE_W-1:0]        price_q;
  logic signed [MACD_W-1:0]  macd_q;
  logic signed [PROD_W-1:0]  prod_q;
  order_dir_e                dir_q;

  // Output register
  logic                      out_valid_q;
  order_dir_e                dir_out_q;
  logic signed [POS_W-1:0]   held_out_q;
  logic signed [CASH_W-1:0]  cash_out_q;
  logic signed [CASH_W-1:0]  settled_out_q;
  logic signed [MACD_W-1:0]  macd_out_q;
  logic signed [MACD_W-1:0]  sig_out_q;

  // Datapath
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;
  logic [AVG_W-1:0]          wide;
  logic [MACD_W-1:0]         slow_diff;
  logic [MACD_W-1:0]         fast_diff;
  logic [NUM_W-2:0]          sig_diff;
  logic signed [POS_W:0]     pos_ext;
  logic signed [POS_W:0]     lim_pos;
  logic signed [POS_W:0]     lim_neg;
  logic signed [CASH_W:0]    cash_ext;
  logic signed [CASH_W:0]    price_ext;
  logic signed [CASH_W:0]    cash_minus;
  logic signed [CASH_W:0]    cash_plus;
  logic signed [CASH_W:0]    settle_sum;
  logic signed [PROD_W-1:0]  prod_d;
  order_dir_e                dir_d;

  function automatic logic [CASH_W-1:0] sat_cash(input logic [CASH_W:0] v);
    logic [CASH_W-1:0] r;
    r = v[CASH_W-1:0];
    if (v[CASH_W] != v[CASH_W-1]) begin
      r = v[CASH_W] ? {1'b1, {(CASH_W-1){1'b0}}} : {1'b0, {(CASH_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Control word fetch and step selection
  assign ctl = ucode_rom(step_q);

  always_comb begin
    unique case (ctl.hold)
      HOLD_IN:  stall = !in_valid_i;
      HOLD_DIV: stall = !div_rsp.done;
      HOLD_OUT: stall = out_valid_q && !out_ready_i;
      default:  stall = 1'b0;
    endcase
  end

  assign exec = !stall;

  always_comb begin
    unique case (ctl.jump)
      JMP_ALWAYS:    jump_taken = 1'b1;
      JMP_NOT_FIRST: jump_taken = !first_sample_i;
      default:       jump_taken = 1'b0;
    endcase
  end

  assign step_d = stall      ? step_q     :
                  jump_taken ? ctl.target : step_q + 1'b1;

  assign in_ready_o  = (ctl.hold == HOLD_IN);
  assign cfg_ready_o = 1'b1;

  // EMA differences, two's complement wraps safely at these widths
  assign wide      = {price_q, {EXTRA_FRAC_BITS{1'b0}}};
  assign slow_diff = {1'b0, wide} - {1'b0, slow_q};
  assign fast_diff = {1'b0, wide} - {1'b0, fast_q};
  assign sig_diff  = {macd_q[MACD_W-1], macd_q} - {sig_q[MACD_W-1], sig_q};

  // Divider request decode
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = SLOW_DEN;
    unique case (ctl.uop)
      UOP_DIV_SLOW: begin
        div_req.start = 1'b1;
        div_req.num   = $signed({slow_diff[MACD_W-1], slow_diff, 1'b0});
        div_req.den   = SLOW_DEN;
      end
      UOP_DIV_FAST: begin
        div_req.start = 1'b1;
        div_req.num   = $signed({fast_diff[MACD_W-1], fast_diff, 1'b0});
        div_req.den   = FAST_DEN;
      end
      UOP_DIV_SIG: begin
        div_req.start = 1'b1;
        div_req.num   = $signed({sig_diff, 1'b0});
        div_req.den   = SIGNAL_DEN;
      end
      default: ;
    endcase
  end

  mct_cdiv u_cdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Crossover decision against the position limit
  assign pos_ext = $signed({pos_q[POS_W-1], pos_q});
  assign lim_pos = $signed({1'b0, 1'b0, limit_q});
  assign lim_neg = -lim_pos;

  always_comb begin
    dir_d = DIR_NONE;
    if (macd_q > sig_q) begin
      if (pos_ext < lim_pos) dir_d = DIR_BUY;
    end else if (macd_q < sig_q) begin
      if (pos_ext > lim_neg) dir_d = DIR_SELL;
    end
  end

  // Cash and mark-to-market arithmetic
  assign cash_ext   = $signed({cash_q[CASH_W-1], cash_q});
  assign price_ext  = $signed({{(CASH_W+1-PRICE_W){1'b0}}, price_q});
  assign cash_minus = cash_ext - price_ext;
  assign cash_plus  = cash_ext + price_ext;
  assign prod_d     = $signed({1'b0, price_q}) * pos_q;
  assign settle_sum = cash_ext + $signed({{(CASH_W+1-PROD_W){prod_q[PROD_W-1]}}, prod_q});

  // Sequencer, architectural state and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      slow_q      <= '0;
      fast_q      <= '0;
      sig_q       <= '0;
      pos_q       <= '0;
      cash_q      <= '0;
      limit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (cfg_valid_i) limit_q <= position_limit_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (exec) begin
        unique case (ctl.uop)
          UOP_INIT: begin
            slow_q <= wide;
            fast_q <= wide;
            sig_q  <= '0;
            pos_q  <= '0;
            cash_q <= '0;
          end
          UOP_WB_SLOW: slow_q <= slow_q + div_rsp.quot[AVG_W-1:0];
          UOP_WB_FAST: fast_q <= fast_q + div_rsp.quot[AVG_W-1:0];
          UOP_WB_SIG:  sig_q  <= sig_q + $signed(div_rsp.quot[MACD_W-1:0]);
          UOP_TRADE: begin
            if (dir_d == DIR_BUY) begin
              pos_q  <= pos_q + POS_W'(1);
              cash_q <= $signed(sat_cash(cash_minus));
            end else if (dir_d == DIR_SELL) begin
              pos_q  <= pos_q - POS_W'(1);
              cash_q <= $signed(sat_cash(cash_plus));
            end
          end
          UOP_SETTLE: out_valid_q <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk_i) begin
    if (exec) begin
      unique case (ctl.uop)
        UOP_LATCH: price_q <= close_price_i;
        UOP_MACD:  macd_q  <= $signed({1'b0, fast_q} - {1'b0, slow_q});
        UOP_TRADE: dir_q   <= dir_d;
        UOP_MUL:   prod_q  <= prod_d;
        UOP_SETTLE: begin
          dir_out_q     <= dir_q;
          held_out_q    <= pos_q;
          cash_out_q    <= cash_q;
          settled_out_q <= $signed(sat_cash(settle_sum));
          macd_out_q    <= macd_q;
          sig_out_q     <= sig_q;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign order_dir_o     = dir_out_q;
  assign held_units_o    = held_out_q;
  assign cash_balance_o  = cash_out_q;
  assign settled_value_o = settled_out_q;
  assign macd_value_o    = macd_out_q;
  assign signal_value_o  = sig_out_q;

  // Checks
  a_div_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_waited : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> ctl.hold == HOLD_DIV)
    else $error("quotient ready with no step waiting for it");

  a_buy_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && ctl.uop == UOP_TRADE && dir_d == DIR_BUY)
      |=> pos_q == $past(pos_q) + POS_W'(1))
    else $error("buy did not raise the position by one");

endmodule

[hw/rtl/mct_cdiv.sv]
// Signed divide by a small constant, truncating toward zero.
// Restoring long division on the magnitude, four quotient bits per cycle.
module mct_cdiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mct_pkg::div_req_t req_i,
  output mct_pkg::div_rsp_t rsp_o
);
  import mct_pkg::*;

  localparam int unsigned DIGITS = 4;
  localparam int unsigned CYCLES = (NUM_W + DIGITS - 1) / DIGITS;
  localparam int unsigned WORK_W = CYCLES * DIGITS;
  localparam int unsigned CNT_W  = $clog2(CYCLES + 1);

  logic              busy_q;
  logic              done_q;
  logic              neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [WORK_W-1:0] work_q, work_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q;
  logic [NUM_W-1:0]  mag;
  logic [NUM_W-1:0]  quot_mag;
  logic [NUM_W-1:0]  quot_bits;

  // magnitude of the dividend; the most negative value maps to 2^(NUM_W-1)
  assign mag = req_i.num[NUM_W-1] ? (~req_i.num + 1'b1) : req_i.num;

  // four shift/compare/subtract steps; remainder stays below the divisor
  always_comb begin
    logic [DEN_W:0] trial;
    work_d = work_q;
    rem_d  = rem_q;
    for (int k = 0; k < DIGITS; k++) begin
      trial  = {rem_d, work_d[WORK_W-1]};
      work_d = {work_d[WORK_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial     = trial - {1'b0, den_q};
        work_d[0] = 1'b1;
      end
      rem_d = trial[DEN_W-1:0];
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(CYCLES);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend/quotient shift register and remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      work_q <= WORK_W'(mag);
      rem_q  <= '0;
      den_q  <= req_i.den;
      neg_q  <= req_i.num[NUM_W-1];
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign quot_mag  = work_q[NUM_W-1:0];
  assign quot_bits = neg_q ? (~quot_mag + 1'b1) : quot_mag;

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = $signed(quot_bits);

  // Checks
  a_busy_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with an exhausted count");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still iterating");

  a_done_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == CNT_W'(1) && !req_i.start) |=> done_q)
    else $error("divider finished without a done pulse");

endmodule

[bench/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mct_pkg::*;

  // One price beat offered to the block
  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               first;
  } price_item_t;

  // One trading report as the block returns it
  typedef struct packed {
    order_dir_e                dir;
    logic signed [POS_W-1:0]   units;
    logic signed [CASH_W-1:0]  cash;
    logic signed [CASH_W-1:0]  settled;
    logic signed [MACD_W-1:0]  macd;
    logic signed [MACD_W-1:0]  signal;
  } trade_report_t;

  localparam longint CASH_TOP    = 64'sd4611686018427387903;
  localparam longint CASH_BOTTOM = -CASH_TOP - 64'sd1;
  localparam longint PRICE_TOP   = 64'sd4294967295;
  localparam longint ONE_UNIT    = 64'sd65536;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [PRICE_W-1:0]        close_price_i = '0;
  logic                      first_sample_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [1:0]                order_dir_o;
  logic signed [POS_W-1:0]   held_units_o;
  logic signed [CASH_W-1:0]  cash_balance_o;
  logic signed [CASH_W-1:0]  settled_value_o;
  logic signed [MACD_W-1:0]  macd_value_o;
  logic signed [MACD_W-1:0]  signal_value_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [LIMIT_W-1:0]        position_limit_i = '0;

  // Bench-side copy of the trader state
  logic [AVG_W-1:0]          slow_ema;
  logic [AVG_W-1:0]          fast_ema;
  logic signed [MACD_W-1:0]  signal_ema;
  logic signed [POS_W-1:0]   units_held;
  logic signed [CASH_W-1:0]  cash_held;
  logic [LIMIT_W-1:0]        limit_setting;

  price_item_t   price_backlog[$];
  trade_report_t reports_due[$];
  price_item_t   offered;
  trade_report_t got;
  trade_report_t want;

  int  mismatches = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  logic idle_en = 1'b1;
  logic hold_out = 1'b0;

  macd_crossover_trader dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .close_price_i   (close_price_i),
    .first_sample_i  (first_sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .order_dir_o     (order_dir_o),
    .held_units_o    (held_units_o),
    .cash_balance_o  (cash_balance_o),
    .settled_value_o (settled_value_o),
    .macd_value_o    (macd_value_o),
    .signal_value_o  (signal_value_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .position_limit_i(position_limit_i)
  );

  always #10ns clk_i = ~clk_i;

  // EMA step with alpha 2/den, quotient truncated toward zero
  function automatic longint ema_update(input longint avg, input longint target,
                                        input longint den);
    return avg + (64'sd2 * (target - avg)) / den;
  endfunction

  function automatic longint clamp_cash(input longint v);
    if (v > CASH_TOP) return CASH_TOP;
    if (v < CASH_BOTTOM) return CASH_BOTTOM;
    return v;
  endfunction

  // Advance the trader by one price and return the report it should give
  function automatic trade_report_t advance_trader(input price_item_t it);
    longint px, wide, slow, fast, macd, sig, pos, cash, lim;
    trade_report_t r;
    px   = longint'(it.price);
    wide = px << EXTRA_FRAC_BITS;
    slow = longint'(slow_ema);
    fast = longint'(fast_ema);
    sig  = longint'(signal_ema);
    pos  = longint'(units_held);
    cash = longint'(cash_held);
    lim  = longint'(limit_setting);
    r.dir = DIR_NONE;
    // a new series reloads the averages and clears the book
    if (it.first) begin
      slow = wide;
      fast = wide;
      sig  = 0;
      pos  = 0;
      cash = 0;
    end
    slow = ema_update(slow, wide, 27);
    fast = ema_update(fast, wide, 13);
    macd = fast - slow;
    sig  = ema_update(sig, macd, 10);
    // crossover decision, bounded by the position limit
    if (macd > sig) begin
      if (pos < lim) begin
        pos++;
        cash  = clamp_cash(cash - px);
        r.dir = DIR_BUY;
      end
    end else if (macd < sig) begin
      if (pos > -lim) begin
        pos--;
        cash  = clamp_cash(cash + px);
        r.dir = DIR_SELL;
      end
    end
    slow_ema   = AVG_W'(slow);
    fast_ema   = AVG_W'(fast);
    signal_ema = MACD_W'(sig);
    units_held = POS_W'(pos);
    cash_held  = CASH_W'(cash);
    r.units    = POS_W'(pos);
    r.cash     = CASH_W'(cash);
    r.settled  = CASH_W'(clamp_cash(cash + px * pos));
    r.macd     = MACD_W'(macd);
    r.signal   = MACD_W'(sig);
    return r;
  endfunction

  function automatic void report_mismatch(input string field, input longint e,
                                          input longint a);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d got %0d", $realtime, field, e, a);
  endfunction

  function automatic void queue_price(input longint p, input logic f);
    price_item_t it;
    it.price = PRICE_W'(p);
    it.first = f;
    price_backlog.push_back(it);
  endfunction

  // Price series: a first-sample beat, then a drifting walk; some noise beats
  task automatic queue_prices(input int total);
    longint level, drift;
    int     run, i;
    while (total > 0) begin
      run = $urandom_range(8, 50);
      if (run > total) run = total;
      if ($urandom_range(0, 3) == 0) level = longint'($urandom);
      else level = longint'($urandom_range(32'h0010_0000, 32'h0400_0000));
      drift = longint'($urandom_range(0, 1 << 19)) - (64'sd1 << 18);
      for (i = 0; i < run; i++) begin
        if (i > 0 && $urandom_range(0, 9) == 0) begin
          queue_price(longint'($urandom), 1'($urandom_range(0, 1)));
        end else begin
          if ($urandom_range(0, 7) == 0)
            drift = longint'($urandom_range(0, 1 << 19)) - (64'sd1 << 18);
          level += drift + longint'($urandom_range(0, 1 << 17)) - (64'sd1 << 16);
          if (level < 0) level = 0;
          if (level > PRICE_TOP) level = PRICE_TOP;
          queue_price(level, i == 0);
        end
      end
      total -= run;
    end
  endtask

  task automatic wait_idle();
    while (price_backlog.size() != 0 || in_valid_i || reports_due.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] lim);
    @(posedge clk_i);
    cfg_valid_i      <= 1'b1;
    position_limit_i <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    limit_setting  = lim;
  endtask

  // Price driver: predicts on each accepted beat, then offers the next
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        reports_due.push_back(advance_trader(offered));
      if (!in_valid_i || in_ready_o) begin
        if (send_gap == 0 && idle_en && $urandom_range(0, 5) == 0)
          send_gap = $urandom_range(1, 16);
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (price_backlog.size() != 0) begin
          offered = price_backlog.pop_front();
          close_price_i  <= offered.price;
          first_sample_i <= offered.first;
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Report monitor: checks each beat against the oldest expectation
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '{order_dir_e'(order_dir_o), held_units_o, cash_balance_o,
                settled_value_o, macd_value_o, signal_value_o};
        if (reports_due.size() == 0) begin
          report_mismatch("unexpected report, order_dir", -1, longint'(got.dir));
        end else begin
          want = reports_due.pop_front();
          if (got.dir !== want.dir)
            report_mismatch("order_dir", longint'(want.dir), longint'(got.dir));
          if (got.units !== want.units)
            report_mismatch("held_units", longint'(want.units), longint'(got.units));
          if (got.cash !== want.cash)
            report_mismatch("cash_balance", longint'(want.cash), longint'(got.cash));
          if (got.settled !== want.settled)
            report_mismatch("settled_value", longint'(want.settled),
                            longint'(got.settled));
          if (got.macd !== want.macd)
            report_mismatch("macd_value", longint'(want.macd), longint'(got.macd));
          if (got.signal !== want.signal)
            report_mismatch("signal_value", longint'(want.signal),
                            longint'(got.signal));
        end
      end
      if (recv_gap == 0 && idle_en && $urandom_range(0, 5) == 0)
        recv_gap = $urandom_range(1, 16);
      if (hold_out) begin
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [LIMIT_W-1:0] phase_limit[6];
    int k;
    slow_ema      = '0;
    fast_ema      = '0;
    signal_ema    = '0;
    units_held    = '0;
    cash_held     = '0;
    limit_setting = '0;
    phase_limit   = '{16'hFFFF, 16'd0, 16'd1, 16'd0, 16'd7, 16'd3};
    phase_limit[3] = LIMIT_W'($urandom_range(2, 40));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset limit of zero: no series start, then price extremes, no orders
    queue_price(ONE_UNIT, 1'b0);
    queue_price(PRICE_TOP, 1'b1);
    queue_price(0, 1'b0);
    queue_price(PRICE_TOP, 1'b0);
    wait_idle();

    // small limit: flat prices give equal lines, then trend up and down
    write_limit(16'd2);
    for (k = 0; k < 3; k++) queue_price(100 * ONE_UNIT, k == 0);
    for (k = 1; k <= 5; k++) queue_price((100 + 2 * k) * ONE_UNIT, 1'b0);
    for (k = 1; k <= 6; k++) queue_price((110 - 3 * k) * ONE_UNIT, 1'b0);
    wait_idle();

    // limit lowered under the held position
    write_limit(16'd1);
    for (k = 1; k <= 3; k++) queue_price((92 - 3 * k) * ONE_UNIT, 1'b0);
    for (k = 1; k <= 3; k++) queue_price((83 + 4 * k) * ONE_UNIT, 1'b0);
    wait_idle();

    // random series over a range of limits
    for (k = 0; k < 6; k++) begin
      write_limit(phase_limit[k]);
      if (k == 5) idle_en <= 1'b0;
      queue_prices(130);
      if (k == 3) begin
        // long output stall so the block backs up onto its input
        hold_out <= 1'b1;
        repeat (600) @(posedge clk_i);
        hold_out <= 1'b0;
      end
      wait_idle();
    end

    repeat (60) @(posedge clk_i);
    mismatches += reports_due.size();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/mct_pkg.sv
hw/rtl/mct_cdiv.sv
hw/rtl/macd_crossover_trader.sv
bench/tb_top.sv
